@@ design/rgb_image_error_metrics_assert.svh @@
// assertion macros shared by the rgb image error metrics rtl
// expects clk and arst_n in the scope of each use
`ifndef RGB_IMAGE_ERROR_METRICS_ASSERT_SVH
`define RGB_IMAGE_ERROR_METRICS_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RGBIEM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rgb_image_error_metrics: check failed");

// next-cycle implication, checked outside reset
`define RGBIEM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rgb_image_error_metrics: check failed");

`endif

@@ design/rgbiem_pkg.sv @@
// shared types, constants and helpers for the rgb image error metrics block
// no dependencies
package rgbiem_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int POS_W     = 16;
	localparam int VALUE_W   = 17;
	localparam int KIND_W    = 3;
	localparam int SQ_W      = 2 * SAMPLE_W;
	localparam int DSQ_W     = 2 * SAMPLE_W + 2;
	localparam int ROOT_IN_W = 64;
	localparam int ROOT_W    = ROOT_IN_W / 2;

	localparam logic [VALUE_W-1:0] VALUE_MAX   = '1;
	localparam logic [POS_W-1:0]   WIDTH_RESET = 16'd1024;

	localparam logic [KIND_W-1:0] KIND_RED   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_GREEN = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BLUE  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DIST  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_RMSE  = 3'd4;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t red;
		sample_t green;
		sample_t blue;
	} pixel_t;

	typedef struct packed {
		logic load;
		logic seen;
		logic update;
		logic clear;
	} lane_ctl_t;

	typedef struct packed {
		logic             take;
		sample_t          max_err;
		logic [SQ_W-1:0]  sq;
	} lane_stat_t;

	function automatic logic [VALUE_W-1:0] sat_value(input logic [ROOT_W-1:0] v);
		if (v > ROOT_W'(VALUE_MAX))
			return VALUE_MAX;
		return v[VALUE_W-1:0];
	endfunction

endpackage

@@ design/rgbiem_lane.sv @@
// one color channel lane: absolute difference, its square, running maximum
// depends on rgbiem_pkg
module rgbiem_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rgbiem_pkg::lane_ctl_t ctl,
	input  rgbiem_pkg::sample_t   left,
	input  rgbiem_pkg::sample_t   right,
	output rgbiem_pkg::lane_stat_t stat
);

	rgbiem_pkg::sample_t             diff;
	rgbiem_pkg::sample_t             diff_s1;
	logic [rgbiem_pkg::SQ_W-1:0]     sq_s1;
	rgbiem_pkg::sample_t             max_q;
	logic                            take;

	assign diff = (left > right) ? left - right : right - left;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			diff_s1 <= diff;
			sq_s1   <= rgbiem_pkg::SQ_W'(diff) * rgbiem_pkg::SQ_W'(diff);
		end
	end

	// first pixel of an image always wins, ties keep the older one
	assign take = !ctl.seen || (diff_s1 > max_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
		end else if (ctl.clear) begin
			max_q <= '0;
		end else if (ctl.update && take) begin
			max_q <= diff_s1;
		end
	end

	assign stat.take    = take;
	assign stat.max_err = max_q;
	assign stat.sq      = sq_s1;

endmodule

@@ design/rgbiem_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on nothing
module rgbiem_div #(
	parameter int N_BITS = 58,
	parameter int D_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [N_BITS-1:0] num,
	input  logic [D_BITS-1:0] den,
	output logic              busy,
	output logic [N_BITS-1:0] quo
);

	localparam int CNT_W = $clog2(N_BITS + 1);

	logic [D_BITS-1:0] rem_q;
	logic [D_BITS-1:0] den_q;
	logic [N_BITS-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [D_BITS:0]   sh;
	logic              ge;

	assign sh = {rem_q, quo_q[N_BITS-1]};
	assign ge = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(N_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? D_BITS'(sh - {1'b0, den_q}) : D_BITS'(sh);
			quo_q <= {quo_q[N_BITS-2:0], ge};
		end
	end

	assign busy = cnt_q != '0;
	assign quo  = quo_q;

endmodule

@@ design/rgbiem_sqrt.sv @@
// floor square root, one result bit per cycle
// depends on rgbiem_pkg
module rgbiem_sqrt (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [rgbiem_pkg::ROOT_IN_W-1:0]    op,
	output logic                                busy,
	output logic [rgbiem_pkg::ROOT_W-1:0]       root
);

	localparam int W = rgbiem_pkg::ROOT_IN_W;

	logic [W-1:0] n_q;
	logic [W-1:0] res_q;
	logic [W-1:0] bit_q;
	logic [W-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (start) begin
			bit_q <= W'(1) << (W - 2);
		end else begin
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= op;
			res_q <= '0;
		end else if (bit_q != '0) begin
			if (n_q >= trial) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	assign busy = bit_q != '0;
	assign root = res_q[rgbiem_pkg::ROOT_W-1:0];

endmodule

@@ design/rgb_image_error_metrics.sv @@
// rgb image error metrics top level: lanes, merge, report sequencer
// depends on rgbiem_pkg, rgbiem_lane, rgbiem_div, rgbiem_sqrt, assert macros
//
// channel   signals                               request moves
// pixel     pixel_valid / pixel_stall             left/right rgb samples, final_pixel
// report    report_valid / report_stall           one metric record
// config    image_width_we / image_width_data     image width, written at once
//
// pixels: one per cycle while pixel_stall is low, two pipeline stages (lane square, then merge and compare)
// after the final pixel the block stalls pixels until the last record is loaded for output:
//   the first root runs beside the divider, then the mean root, then five records, which
//   report stalls hold back
// reset: arst_n clears counters, maxima and the sequencer; width returns to 1024
// report_stall holds the current record; the next one waits in the sequencer
`include "rgb_image_error_metrics_assert.svh"

module rgb_image_error_metrics #(
	parameter int COUNT_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        image_width_we,
	input  logic [15:0] image_width_data,
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  logic [15:0] left_red,
	input  logic [15:0] left_green,
	input  logic [15:0] left_blue,
	input  logic [15:0] right_red,
	input  logic [15:0] right_green,
	input  logic [15:0] right_blue,
	input  logic        final_pixel,
	output logic        report_valid,
	input  logic        report_stall,
	output logic [2:0]  metric_kind,
	output logic [16:0] metric_value,
	output logic [15:0] at_row,
	output logic [15:0] at_col,
	output logic [15:0] first_red,
	output logic [15:0] first_green,
	output logic [15:0] first_blue,
	output logic [15:0] second_red,
	output logic [15:0] second_green,
	output logic [15:0] second_blue,
	output logic        last_record
);

	localparam int SUM_RAW  = 2 * rgbiem_pkg::SAMPLE_W + 2 + COUNT_BITS;
	localparam int SUM_BITS = (SUM_RAW >= 64) ? 64 : SUM_RAW;
	localparam int POS_W    = rgbiem_pkg::POS_W;
	localparam int DSQ_W    = rgbiem_pkg::DSQ_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ROOT_D = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_ROOT_M = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;

	logic [POS_W-1:0] width_q;
	logic             busy_q;
	logic [POS_W-1:0] row_q;
	logic [POS_W-1:0] col_q;
	logic             accept;
	logic [POS_W:0]   width_ext;
	logic [POS_W:0]   col_inc;

	rgbiem_pkg::pixel_t left_px;
	rgbiem_pkg::pixel_t right_px;

	logic               valid_s1;
	logic               final_s1;
	rgbiem_pkg::pixel_t left_s1;
	rgbiem_pkg::pixel_t right_s1;
	logic [POS_W-1:0]   row_s1;
	logic [POS_W-1:0]   col_s1;

	rgbiem_pkg::lane_ctl_t  lane_ctl;
	rgbiem_pkg::lane_stat_t stat [3];

	rgbiem_pkg::pixel_t ch_left_q  [3];
	rgbiem_pkg::pixel_t ch_right_q [3];
	logic [POS_W-1:0]   ch_row_q   [3];
	logic [POS_W-1:0]   ch_col_q   [3];

	logic                dist_take;
	logic [DSQ_W-1:0]    dsq;
	logic [DSQ_W-1:0]    dist_sq_q;
	rgbiem_pkg::pixel_t  dist_left_q;
	rgbiem_pkg::pixel_t  dist_right_q;
	logic [POS_W-1:0]    dist_row_q;
	logic [POS_W-1:0]    dist_col_q;
	logic [SUM_BITS-1:0] sum_q;
	logic [SUM_BITS:0]   sum_add;
	logic [COUNT_BITS-1:0] count_q;
	logic                seen_q;

	logic [2:0]  state_q;
	logic [2:0]  rec_q;
	logic        start_q;
	logic        clear;
	logic        load_rec;
	logic [16:0] dist_root_q;
	logic [16:0] rms_q;

	logic                                  div_busy;
	logic [SUM_BITS-1:0]                   quo;
	logic                                  sq_busy;
	logic [rgbiem_pkg::ROOT_W-1:0]         root;
	logic [rgbiem_pkg::ROOT_IN_W-1:0]      root_op;

	logic [2:0]         kind_q;
	logic [16:0]        value_q;
	logic [POS_W-1:0]   at_row_q;
	logic [POS_W-1:0]   at_col_q;
	rgbiem_pkg::pixel_t first_q;
	rgbiem_pkg::pixel_t second_q;
	logic               rv_q;

	// input side
	assign pixel_stall = busy_q;
	assign accept      = pixel_valid && !busy_q;
	assign left_px     = '{red: left_red, green: left_green, blue: left_blue};
	assign right_px    = '{red: right_red, green: right_green, blue: right_blue};

	// width zero counts as 65536
	assign width_ext = (width_q == '0) ? {1'b1, {POS_W{1'b0}}} : {1'b0, width_q};
	assign col_inc   = {1'b0, col_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= rgbiem_pkg::WIDTH_RESET;
		end else if (image_width_we) begin
			width_q <= image_width_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
			final_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			final_s1 <= accept && final_pixel;
			if (accept) begin
				if (final_pixel) begin
					row_q <= '0;
					col_q <= '0;
				end else if (col_inc >= width_ext) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_inc[POS_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_s1  <= left_px;
			right_s1 <= right_px;
			row_s1   <= row_q;
			col_s1   <= col_q;
		end
	end

	// lanes
	assign lane_ctl.load   = accept;
	assign lane_ctl.seen   = seen_q;
	assign lane_ctl.update = valid_s1;
	assign lane_ctl.clear  = clear;

	rgbiem_lane u_lane_r (.clk, .arst_n, .ctl(lane_ctl), .left(left_red),
		.right(right_red), .stat(stat[0]));
	rgbiem_lane u_lane_g (.clk, .arst_n, .ctl(lane_ctl), .left(left_green),
		.right(right_green), .stat(stat[1]));
	rgbiem_lane u_lane_b (.clk, .arst_n, .ctl(lane_ctl), .left(left_blue),
		.right(right_blue), .stat(stat[2]));

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			if (valid_s1 && stat[c].take) begin
				ch_left_q[c]  <= left_s1;
				ch_right_q[c] <= right_s1;
				ch_row_q[c]   <= row_s1;
				ch_col_q[c]   <= col_s1;
			end
		end
	end

	// merge: squared distance, its maximum, saturating sum
	assign dsq = DSQ_W'(stat[0].sq) + DSQ_W'(stat[1].sq) + DSQ_W'(stat[2].sq);
	assign dist_take = !seen_q || (dsq > dist_sq_q);
	assign sum_add   = {1'b0, sum_q} + (SUM_BITS + 1)'(dsq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_sq_q <= '0;
			sum_q     <= '0;
			count_q   <= '0;
			seen_q    <= 1'b0;
		end else if (clear) begin
			dist_sq_q <= '0;
			sum_q     <= '0;
			count_q   <= '0;
			seen_q    <= 1'b0;
		end else if (valid_s1) begin
			seen_q <= 1'b1;
			if (dist_take)
				dist_sq_q <= dsq;
			sum_q <= sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
			if (count_q != '1)
				count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && dist_take) begin
			dist_left_q  <= left_s1;
			dist_right_q <= right_s1;
			dist_row_q   <= row_s1;
			dist_col_q   <= col_s1;
		end
	end

	// report sequencer
	assign root_op  = (state_q == ST_ROOT_D) ? rgbiem_pkg::ROOT_IN_W'(dist_sq_q)
		: rgbiem_pkg::ROOT_IN_W'(quo);
	assign load_rec = (state_q == ST_EMIT) && (!rv_q || !report_stall);
	assign clear    = load_rec && (rec_q == rgbiem_pkg::KIND_RMSE);

	rgbiem_div #(.N_BITS(SUM_BITS), .D_BITS(COUNT_BITS)) u_div (
		.clk, .arst_n,
		.start(start_q && (state_q == ST_ROOT_D)),
		.num(sum_q), .den(count_q), .busy(div_busy), .quo(quo)
	);

	rgbiem_sqrt u_sqrt (
		.clk, .arst_n, .start(start_q), .op(root_op), .busy(sq_busy), .root(root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			start_q <= 1'b0;
			rec_q   <= '0;
		end else begin
			start_q <= 1'b0;
			if (accept && final_pixel)
				busy_q <= 1'b1;
			unique case (state_q)
				ST_IDLE: begin
					if (valid_s1 && final_s1) begin
						state_q <= ST_ROOT_D;
						start_q <= 1'b1;
					end
				end
				ST_ROOT_D: begin
					if (!start_q && !sq_busy)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!div_busy) begin
						state_q <= ST_ROOT_M;
						start_q <= 1'b1;
					end
				end
				ST_ROOT_M: begin
					if (!start_q && !sq_busy) begin
						state_q <= ST_EMIT;
						rec_q   <= rgbiem_pkg::KIND_RED;
					end
				end
				ST_EMIT: begin
					if (clear) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end else if (load_rec) begin
						rec_q <= rec_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ROOT_D && !start_q && !sq_busy)
			dist_root_q <= rgbiem_pkg::sat_value(root);
		if (state_q == ST_ROOT_M && !start_q && !sq_busy)
			rms_q <= rgbiem_pkg::sat_value(root);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else if (load_rec) begin
			rv_q <= 1'b1;
		end else if (!report_stall) begin
			rv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rec) begin
			kind_q <= rec_q;
			case (rec_q)
				rgbiem_pkg::KIND_DIST: begin
					value_q  <= dist_root_q;
					at_row_q <= dist_row_q;
					at_col_q <= dist_col_q;
					first_q  <= dist_left_q;
					second_q <= dist_right_q;
				end
				rgbiem_pkg::KIND_RMSE: begin
					value_q  <= rms_q;
					at_row_q <= '0;
					at_col_q <= '0;
					first_q  <= '0;
					second_q <= '0;
				end
				default: begin
					value_q  <= {1'b0, stat[rec_q[1:0]].max_err};
					at_row_q <= ch_row_q[rec_q[1:0]];
					at_col_q <= ch_col_q[rec_q[1:0]];
					first_q  <= ch_left_q[rec_q[1:0]];
					second_q <= ch_right_q[rec_q[1:0]];
				end
			endcase
		end
	end

	assign report_valid = rv_q;
	assign metric_kind  = kind_q;
	assign metric_value = value_q;
	assign at_row       = at_row_q;
	assign at_col       = at_col_q;
	assign first_red    = first_q.red;
	assign first_green  = first_q.green;
	assign first_blue   = first_q.blue;
	assign second_red   = second_q.red;
	assign second_green = second_q.green;
	assign second_blue  = second_q.blue;
	assign last_record  = kind_q == rgbiem_pkg::KIND_RMSE;

	`RGBIEM_ASSERT_NEXT(a_final_starts_report, valid_s1 && final_s1,
		state_q == ST_ROOT_D && start_q)
	`RGBIEM_ASSERT_NOW(a_report_only_when_busy, state_q != ST_IDLE, busy_q)
	`RGBIEM_ASSERT_NOW(a_no_pixel_in_report, state_q != ST_IDLE, !valid_s1)
	`RGBIEM_ASSERT_NOW(a_rec_in_range, state_q == ST_EMIT,
		rec_q <= rgbiem_pkg::KIND_RMSE)
	`RGBIEM_ASSERT_NEXT(a_clear_empties, clear, !seen_q && count_q == '0 && !busy_q)

endmodule

@@ bench/tb_rgb_image_error_metrics.sv @@
// self-checking bench for rgb_image_error_metrics: random paired pixels, bursty sender,
// stalling receiver, own model of the per-image maxima, distance and rmse records
// depends on rgbiem_pkg and the rgb_image_error_metrics rtl
module tb_rgb_image_error_metrics;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COUNT_BITS = 24;
	localparam int SUM_BITS   = 2 * rgbiem_pkg::SAMPLE_W + 2 + COUNT_BITS;
	localparam logic [63:0] SUM_MAX   = (SUM_BITS >= 64) ? '1 : ((64'd1 << SUM_BITS) - 1);
	localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
	localparam int DRAIN_CYCLES = 200;
	localparam int IDLE_LIMIT   = 5000;
	localparam int HOLD_CYCLES  = 400;

	typedef struct {
		logic [15:0] l [3];
		logic [15:0] r [3];
		logic        fin;
	} px_req_t;

	typedef struct {
		logic [2:0]  kind;
		logic [16:0] value;
		logic [15:0] row;
		logic [15:0] col;
		logic [15:0] f [3];
		logic [15:0] s [3];
		logic        last;
	} metric_rec_t;

	logic clk = 0;
	logic arst_n = 0;
	logic image_width_we = 0;
	logic [15:0] image_width_data = 0;
	logic pixel_valid = 0;
	logic pixel_stall;
	logic [15:0] left_red = 0, left_green = 0, left_blue = 0;
	logic [15:0] right_red = 0, right_green = 0, right_blue = 0;
	logic final_pixel = 0;
	logic report_valid;
	logic report_stall = 0;
	logic [2:0] metric_kind;
	logic [16:0] metric_value;
	logic [15:0] at_row, at_col;
	logic [15:0] first_red, first_green, first_blue;
	logic [15:0] second_red, second_green, second_blue;
	logic last_record;

	rgb_image_error_metrics #(.COUNT_BITS(COUNT_BITS)) dut (
		.clk(clk), .arst_n(arst_n),
		.image_width_we(image_width_we), .image_width_data(image_width_data),
		.pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
		.left_red(left_red), .left_green(left_green), .left_blue(left_blue),
		.right_red(right_red), .right_green(right_green), .right_blue(right_blue),
		.final_pixel(final_pixel),
		.report_valid(report_valid), .report_stall(report_stall),
		.metric_kind(metric_kind), .metric_value(metric_value),
		.at_row(at_row), .at_col(at_col),
		.first_red(first_red), .first_green(first_green), .first_blue(first_blue),
		.second_red(second_red), .second_green(second_green), .second_blue(second_blue),
		.last_record(last_record)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	px_req_t pending_px [$];
	metric_rec_t expected_records [$];
	int errors = 0;
	int idle_cycles = 0;
	logic px_taken = 0;
	logic hold_req = 0;

	// model state of the image being compared
	logic [16:0] img_width = 17'd1024;
	logic [15:0] ch_err [3];
	logic [15:0] ch_row [3];
	logic [15:0] ch_col [3];
	logic [15:0] ch_f [3][3];
	logic [15:0] ch_s [3][3];
	logic [33:0] dist_max;
	logic [15:0] dist_row, dist_col;
	logic [15:0] dist_f [3];
	logic [15:0] dist_s [3];
	logic [63:0] sq_total;
	logic [63:0] px_count;
	logic [15:0] row_cnt, col_cnt;
	logic seen;

	function automatic void clear_image();
		for (int c = 0; c < 3; c++) begin
			ch_err[c] = 0; ch_row[c] = 0; ch_col[c] = 0;
			for (int k = 0; k < 3; k++) begin
				ch_f[c][k] = 0; ch_s[c][k] = 0;
			end
			dist_f[c] = 0; dist_s[c] = 0;
		end
		dist_max = 0; dist_row = 0; dist_col = 0;
		sq_total = 0; px_count = 0; row_cnt = 0; col_cnt = 0; seen = 0;
	endfunction

	function automatic logic [31:0] floor_root(input logic [63:0] n);
		logic [31:0] res;
		logic [31:0] trial;
		res = 0;
		for (int i = 31; i >= 0; i--) begin
			trial = res | (32'd1 << i);
			if (64'(trial) * 64'(trial) <= n)
				res = trial;
		end
		return res;
	endfunction

	function automatic logic [16:0] clip_value(input logic [63:0] v);
		return (v > 64'(rgbiem_pkg::VALUE_MAX)) ? rgbiem_pkg::VALUE_MAX : v[16:0];
	endfunction

	function automatic void absorb_pixel(input px_req_t p);
		logic [15:0] d [3];
		logic [33:0] dsq;
		logic [63:0] sum;
		metric_rec_t rec;
		dsq = 0;
		for (int c = 0; c < 3; c++) begin
			d[c] = (p.l[c] > p.r[c]) ? p.l[c] - p.r[c] : p.r[c] - p.l[c];
			dsq += 34'(d[c]) * 34'(d[c]);
		end
		for (int c = 0; c < 3; c++) begin
			if (!seen || d[c] > ch_err[c]) begin
				ch_err[c] = d[c]; ch_row[c] = row_cnt; ch_col[c] = col_cnt;
				ch_f[c] = p.l; ch_s[c] = p.r;
			end
		end
		if (!seen || dsq > dist_max) begin
			dist_max = dsq; dist_row = row_cnt; dist_col = col_cnt;
			dist_f = p.l; dist_s = p.r;
		end
		seen = 1;
		sum = sq_total + 64'(dsq);
		sq_total = (sq_total > SUM_MAX - 64'(dsq)) ? SUM_MAX : sum;
		if (px_count < COUNT_MAX)
			px_count++;
		if (17'(col_cnt) + 17'd1 >= img_width) begin
			col_cnt = 0;
			row_cnt = row_cnt + 16'd1;
		end else begin
			col_cnt++;
		end
		if (!p.fin)
			return;
		for (int c = 0; c < 3; c++) begin
			rec.kind = 3'(c);
			rec.value = 17'(ch_err[c]);
			rec.row = ch_row[c]; rec.col = ch_col[c];
			rec.f = ch_f[c]; rec.s = ch_s[c];
			rec.last = 0;
			expected_records.push_back(rec);
		end
		rec.kind = rgbiem_pkg::KIND_DIST;
		rec.value = clip_value(64'(floor_root(64'(dist_max))));
		rec.row = dist_row; rec.col = dist_col;
		rec.f = dist_f; rec.s = dist_s;
		rec.last = 0;
		expected_records.push_back(rec);
		rec.kind = rgbiem_pkg::KIND_RMSE;
		rec.value = clip_value(64'(floor_root(sq_total / px_count)));
		rec.row = 0; rec.col = 0;
		for (int c = 0; c < 3; c++) begin
			rec.f[c] = 0; rec.s[c] = 0;
		end
		rec.last = 1;
		expected_records.push_back(rec);
		clear_image();
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic check_record();
		metric_rec_t e;
		if (expected_records.size() == 0) begin
			report_mismatch("unexpected record kind", metric_kind, 0);
			return;
		end
		e = expected_records.pop_front();
		if (metric_kind !== e.kind) report_mismatch("metric_kind", metric_kind, e.kind);
		if (metric_value !== e.value) report_mismatch("metric_value", metric_value, e.value);
		if (at_row !== e.row) report_mismatch("at_row", at_row, e.row);
		if (at_col !== e.col) report_mismatch("at_col", at_col, e.col);
		if (first_red !== e.f[0]) report_mismatch("first_red", first_red, e.f[0]);
		if (first_green !== e.f[1]) report_mismatch("first_green", first_green, e.f[1]);
		if (first_blue !== e.f[2]) report_mismatch("first_blue", first_blue, e.f[2]);
		if (second_red !== e.s[0]) report_mismatch("second_red", second_red, e.s[0]);
		if (second_green !== e.s[1]) report_mismatch("second_green", second_green, e.s[1]);
		if (second_blue !== e.s[2]) report_mismatch("second_blue", second_blue, e.s[2]);
		if (last_record !== e.last) report_mismatch("last_record", last_record, e.last);
	endtask

	// monitor: predict on each accepted pixel, check each accepted record
	always @(posedge clk) begin
		if (arst_n) begin
			px_req_t p;
			logic any;
			any = 0;
			px_taken <= pixel_valid && !pixel_stall;
			if (pixel_valid && !pixel_stall) begin
				p.l[0] = left_red; p.l[1] = left_green; p.l[2] = left_blue;
				p.r[0] = right_red; p.r[1] = right_green; p.r[2] = right_blue;
				p.fin = final_pixel;
				absorb_pixel(p);
				any = 1;
			end
			if (report_valid && !report_stall) begin
				check_record();
				any = 1;
			end
			idle_cycles = any ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// driver: bursts of requests with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (arst_n && (!pixel_valid || px_taken)) begin
			if (gap_left > 0 || pending_px.size() == 0) begin
				pixel_valid <= 0;
				if (gap_left > 0)
					gap_left <= gap_left - 1;
			end else begin
				px_req_t p;
				p = pending_px.pop_front();
				pixel_valid <= 1;
				left_red <= p.l[0]; left_green <= p.l[1]; left_blue <= p.l[2];
				right_red <= p.r[0]; right_green <= p.r[1]; right_blue <= p.r[2];
				final_pixel <= p.fin;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// receiver stall pattern, with one long hold-off
	int stall_mode = 0;
	int mode_left = 0;
	int hold_cnt = 0;
	logic hold_done = 0;
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_cnt <= HOLD_CYCLES;
			hold_done <= 1;
			report_stall <= 1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			report_stall <= (hold_cnt > 1);
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(1, 60);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: report_stall <= 0;
				1: report_stall <= $urandom_range(0, 1);
				2: report_stall <= ($urandom_range(0, 3) == 0);
				default: report_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic queue_px(input logic [15:0] lr, lg, lb, rr, rg, rb, input logic fin);
		px_req_t p;
		p.l[0] = lr; p.l[1] = lg; p.l[2] = lb;
		p.r[0] = rr; p.r[1] = rg; p.r[2] = rb;
		p.fin = fin;
		pending_px.push_back(p);
	endtask

	task automatic queue_random(input logic fin);
		queue_px(pick_sample(), pick_sample(), pick_sample(),
			pick_sample(), pick_sample(), pick_sample(), fin);
	endtask

	// sender stops until every request and record has gone through
	task automatic settle();
		wait (pending_px.size() == 0 && !pixel_valid && expected_records.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_width(input logic [15:0] w);
		@(negedge clk);
		image_width_we <= 1;
		image_width_data <= w;
		img_width = (w == 0) ? 17'h10000 : 17'(w);
		@(negedge clk);
		image_width_we <= 0;
	endtask

	initial begin
		clear_image();
		repeat (3) @(negedge clk);
		arst_n <= 1;
		// reset width, single-pixel images at the extremes
		queue_px(0, 0, 0, 0, 0, 0, 1);
		queue_px(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 1);
		queue_px(0, 16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 1);
		// ties keep the earlier pixel
		queue_px(10, 20, 30, 15, 25, 35, 0);
		queue_px(15, 25, 35, 10, 20, 30, 0);
		queue_px(100, 100, 100, 100, 100, 100, 1);
		settle();
		write_width(16'd3);
		for (int i = 0; i < 7; i++)
			queue_random(i == 6);
		settle();
		// width changed in the middle of an image
		write_width(16'd5);
		for (int i = 0; i < 7; i++)
			queue_random(0);
		settle();
		write_width(16'd3);
		for (int i = 0; i < 4; i++)
			queue_random(i == 3);
		settle();
		write_width(16'd0);
		queue_random(0);
		queue_random(1);
		settle();
		write_width(16'hFFFF);
		queue_random(0);
		queue_random(1);
		settle();
		// random images of small sizes, with a long receiver hold-off early on
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_width(16'd2);
				1: write_width(16'($urandom_range(1, 9)));
				2: write_width(16'hFFFF);
				default: write_width(16'd1);
			endcase
			if (ph == 0)
				hold_req = 1;
			for (int img = 0; img < 5; img++) begin
				int n;
				n = $urandom_range(1, 7);
				for (int i = 0; i < n; i++)
					queue_random(i == n - 1);
			end
			settle();
		end
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
